@@ design/i2c_rx_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package i2c_rx_pkg;

	localparam int unsigned PADDR_W   = 3;
	localparam int unsigned PDATA_W   = 32;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned BIT_IDX_W = 4;

	localparam logic [PADDR_W-1:0] REG_BYTES_EXPECTED = 3'd0;
	localparam logic [BYTE_W-1:0]  BYTES_EXPECTED_RST = 8'd1;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_ARMED    = 3'd1,
		PH_STARTED  = 3'd2,
		PH_RECV     = 3'd3,
		PH_ACK_LOW  = 3'd4,
		PH_ACK_HIGH = 3'd5
	} phase_t;

	typedef struct packed {
		logic scl_level;
		logic sda_level;
	} sample_t;

	typedef struct packed {
		logic              sda_pull_low;
		logic              byte_valid;
		logic [BYTE_W-1:0] received_byte;
		logic              last_byte;
		logic              bus_error;
	} result_t;

endpackage

`default_nettype wire

@@ design/i2c_target_byte_receiver.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                     Payload
// sample    in         sample_valid / sample_stall   sample_t (scl_level, sda_level)
// result    out        result_valid / result_stall   result_t (one per sample)
// config    in         APB psel/penable/pwrite       bytes_expected at address 0
//
// A new sample is taken every cycle while sample_stall is low.
// The bus state machine advances at the clock edge that accepts a sample.
// Results go to an output register backed by one skid register, so sample_stall
// rises only after the output has been stalled while holding two results.
// Reset puts the receiver in the wait-for-start state with bytes_expected at 1.

module i2c_target_byte_receiver (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               sample_valid,
	output logic                              sample_stall,
	input  i2c_rx_pkg::sample_t               sample,
	output logic                              result_valid,
	input  wire                               result_stall,
	output i2c_rx_pkg::result_t               result,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [i2c_rx_pkg::PADDR_W-1:0]    paddr,
	input  wire  [i2c_rx_pkg::PDATA_W-1:0]    pwdata,
	output logic [i2c_rx_pkg::PDATA_W-1:0]    prdata,
	output logic                              pready
);
	import i2c_rx_pkg::*;

	logic [BYTE_W-1:0]    bytes_expected_q;
	phase_t               phase_q, phase_d;
	logic [BIT_IDX_W-1:0] bit_index_q, bit_index_d;
	logic [BYTE_W-1:0]    shift_value_q, shift_value_d;
	logic                 held_bit_q, held_bit_d;
	logic                 bit_sampled_q, bit_sampled_d;
	logic [BYTE_W-1:0]    bytes_left_q, bytes_left_d;

	result_t              res_d;
	result_t              out_q, skid_q;
	logic                 out_valid_q, skid_valid_q;
	logic                 accept, out_free;

	logic                 scl, sda;
	logic                 fall_done;
	logic                 ack_done;
	logic [BYTE_W-1:0]    left_dec;
	logic [BIT_IDX_W-1:0] idx_inc;

	assign scl = sample.scl_level;
	assign sda = sample.sda_level;

	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr == REG_BYTES_EXPECTED) begin
			prdata[BYTE_W-1:0] = bytes_expected_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_expected_q <= BYTES_EXPECTED_RST;
		end else if (psel && penable && pwrite && pready && paddr == REG_BYTES_EXPECTED) begin
			bytes_expected_q <= pwdata[BYTE_W-1:0];
		end
	end

	assign idx_inc   = bit_index_q + BIT_IDX_W'(1);
	assign left_dec  = bytes_left_q - BYTE_W'(1);
	assign fall_done = (phase_q == PH_RECV) && bit_sampled_q && !scl;
	assign ack_done  = (phase_q == PH_ACK_HIGH) && !scl;

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_IDLE: begin
				phase_d = (scl && sda) ? PH_ARMED : PH_IDLE;
			end
			PH_ARMED: begin
				if (!scl) begin
					phase_d = PH_IDLE;
				end else if (!sda) begin
					phase_d = PH_STARTED;
				end
			end
			PH_STARTED: begin
				if (!scl) begin
					phase_d = (bytes_expected_q == '0) ? PH_IDLE : PH_RECV;
				end
			end
			PH_RECV: begin
				if (bit_sampled_q && scl && !held_bit_q && sda) begin
					phase_d = PH_IDLE;
				end else if (fall_done && idx_inc[BIT_IDX_W-1]) begin
					phase_d = PH_ACK_LOW;
				end
			end
			PH_ACK_LOW: begin
				if (scl) begin
					phase_d = PH_ACK_HIGH;
				end
			end
			PH_ACK_HIGH: begin
				if (!scl) begin
					phase_d = (left_dec == '0) ? PH_IDLE : PH_RECV;
				end
			end
			default: begin
				phase_d = (scl && sda) ? PH_ARMED : PH_IDLE;
			end
		endcase
	end

	always_comb begin
		bit_index_d   = bit_index_q;
		shift_value_d = shift_value_q;
		held_bit_d    = held_bit_q;
		bit_sampled_d = bit_sampled_q;
		bytes_left_d  = bytes_left_q;
		res_d         = '0;
		case (phase_q)
			PH_STARTED: begin
				if (!scl) begin
					bytes_left_d  = bytes_expected_q;
					bit_index_d   = '0;
					shift_value_d = '0;
					bit_sampled_d = 1'b0;
					held_bit_d    = 1'b0;
				end
			end
			PH_RECV: begin
				if (!bit_sampled_q) begin
					if (scl) begin
						held_bit_d    = sda;
						shift_value_d = {shift_value_q[BYTE_W-2:0], sda};
						bit_sampled_d = 1'b1;
					end
				end else if (scl) begin
					if (!held_bit_q && sda) begin
						res_d.bus_error = 1'b1;
						bit_sampled_d   = 1'b0;
					end
				end else begin
					bit_sampled_d = 1'b0;
					bit_index_d   = idx_inc;
				end
			end
			PH_ACK_HIGH: begin
				if (ack_done) begin
					res_d.byte_valid    = 1'b1;
					res_d.received_byte = shift_value_q;
					res_d.last_byte     = (left_dec == '0);
					bytes_left_d        = left_dec;
					bit_index_d         = '0;
					shift_value_d       = '0;
					bit_sampled_d       = 1'b0;
				end
			end
			default: begin
			end
		endcase
		res_d.sda_pull_low = (phase_d == PH_ACK_LOW) || (phase_d == PH_ACK_HIGH);
	end

	assign sample_stall = skid_valid_q;
	assign accept       = sample_valid && !sample_stall;
	assign out_free     = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			bit_index_q   <= '0;
			shift_value_q <= '0;
			held_bit_q    <= 1'b0;
			bit_sampled_q <= 1'b0;
			bytes_left_q  <= '0;
		end else if (accept) begin
			phase_q       <= phase_d;
			bit_index_q   <= bit_index_d;
			shift_value_q <= shift_value_d;
			held_bit_q    <= held_bit_d;
			bit_sampled_q <= bit_sampled_d;
			bytes_left_q  <= bytes_left_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q  <= skid_valid_q || accept;
				skid_valid_q <= 1'b0;
			end else if (accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res_d;
			end
		end else if (accept) begin
			skid_q <= res_d;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`ifndef SYNTH
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while the output register is empty");

	a_sampled_only_in_recv: assert property (@(posedge clk) disable iff (!arst_n)
		bit_sampled_q |-> (phase_q == PH_RECV))
		else $error("bit sampled flag set outside of byte reception");

	a_bit_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_index_q <= 4'd8)
		else $error("bit index ran past eight");

	a_bytes_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RECV || phase_q == PH_ACK_LOW || phase_q == PH_ACK_HIGH)
		|-> (bytes_left_q != '0))
		else $error("transfer active with no bytes left");

	a_byte_and_error_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.byte_valid && out_q.bus_error))
		else $error("byte presented together with a bus error");
`endif

endmodule

`default_nettype wire
